// ===== rtl/core/gra_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid A* search package
// Shared types and constants for the grid path search unit.
// ----------------------------------------------------------------------------
package gra_pkg;

  localparam logic [3:0] MaxRows = 4'd8;
  localparam logic [3:0] MaxCols = 4'd8;

  localparam logic [1:0] CfgRows    = 2'd0;
  localparam logic [1:0] CfgCols    = 2'd1;
  localparam logic [1:0] CfgBlocked = 2'd2;

  typedef struct packed {
    logic [7:0] f;
    logic [6:0] g;
    logic [5:0] node;
    logic [5:0] src;
  } open_entry_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic logic [3:0] absdiff3(input logic [2:0] a, input logic [2:0] b);
    logic [2:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {1'b0, d};
  endfunction

endpackage

// ===== rtl/core/gra_cell.sv =====
// ----------------------------------------------------------------------------
// Open list cell
// One slot of the sorted open list; shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module gra_cell import gra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  open_entry_t new_i,
  input  open_entry_t prev_ent_i,
  input  logic        prev_vld_i,
  input  logic        prev_place_i,
  input  open_entry_t next_ent_i,
  input  logic        next_vld_i,
  output open_entry_t ent_o,
  output logic        vld_o,
  output logic        place_o
);

  logic        vld_q, vld_d;
  open_entry_t ent_q, ent_d;

  assign place_o = !vld_q || (ent_q.f > new_i.f);
  assign ent_o   = ent_q;
  assign vld_o   = vld_q;

  always_comb begin
    vld_d = vld_q;
    ent_d = ent_q;
    if (ctl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctl_i.pop) begin
      vld_d = next_vld_i;
      ent_d = next_ent_i;
    end else if (ctl_i.push && place_o) begin
      if (prev_place_i) begin
        vld_d = prev_vld_i;
        ent_d = prev_ent_i;
      end else begin
        vld_d = 1'b1;
        ent_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== rtl/core/grid_astar_path_search_unit.sv =====
// ----------------------------------------------------------------------------
// Grid A* path search unit
// A* over an 8x8 blocked-cell grid, four neighbors, Manhattan heuristic.
// ----------------------------------------------------------------------------
// Usage: write rows_in_use, cols_in_use and blocked_map through the cfg
// channel (always ready) while busy is low. A search transaction is taken
// when start is high and busy is low; busy stays high until the cycle that
// carries the last result. Results appear one per strobe on result_valid_o,
// start cell first, last_o marking the final one; a failed search gives a
// single result with found_o low. The receiver cannot stall results.
// After the accepting edge a setup step seeds the open list with the start
// cell; the search then pops open entries in order of f, skips cells already
// visited and examines the four neighbors of each expanded cell, then walks
// back through the parent memory from the goal and emits the results. Search
// time is set by the single pop/insert port of the sorted open-list chain and
// the one-port parent memory.
// Reset clears the registers to an 8x8 open grid and empties the open list.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit import gra_pkg::*; #(
  parameter int unsigned OPEN_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  start_row_i,
  input  logic [2:0]  start_col_i,
  input  logic [2:0]  goal_row_i,
  input  logic [2:0]  goal_col_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        result_valid_o,
  output logic        found_o,
  output logic [2:0]  path_row_o,
  output logic [2:0]  path_col_o,
  output logic [5:0]  step_index_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_POP, ST_EXPAND, ST_TRACE, ST_TRACE_WAIT,
    ST_EMIT, ST_EMIT_OUT, ST_FAIL
  } state_e;

  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  state_e      state_q;
  logic [3:0]  rows_q, cols_q;
  logic [63:0] blocked_q;
  logic [63:0] visited_q;
  logic [5:0]  start_cell_q, goal_cell_q;
  open_entry_t cur_q;
  logic [1:0]  dir_q;
  logic [5:0]  at_q, n_q, k_q;
  logic [6:0]  len_q;
  logic        res_vld_q, res_found_q, res_last_q;
  logic [5:0]  res_cell_q, res_idx_q;

  logic [5:0]  parent_mem [64];
  logic [5:0]  trail_mem [64];
  logic [5:0]  parent_rd_q, trail_rd_q;

  open_entry_t ent   [OPEN_DEPTH];
  logic        vld   [OPEN_DEPTH];
  logic        place [OPEN_DEPTH];
  cell_ctl_t   ctl;
  open_entry_t new_ent;

  logic       accept;
  logic [3:0] nrows, ncols;
  logic       outside;
  logic [3:0] h_start;
  logic [2:0] cur_r, cur_c, nb_r, nb_c;
  logic       nb_in, push_ok;
  logic [5:0] nb_cell;
  logic [6:0] nb_g;
  logic [3:0] nb_h;
  logic       head_new;
  logic [6:0] rd_off;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign nrows   = (rows_q > MaxRows) ? MaxRows : rows_q;
  assign ncols   = (cols_q > MaxCols) ? MaxCols : cols_q;
  assign outside = ({1'b0, start_row_i} >= nrows) || ({1'b0, start_col_i} >= ncols) ||
                   ({1'b0, goal_row_i} >= nrows) || ({1'b0, goal_col_i} >= ncols);
  assign h_start = absdiff3(start_cell_q[5:3], goal_cell_q[5:3]) +
                   absdiff3(start_cell_q[2:0], goal_cell_q[2:0]);

  assign cur_r = cur_q.node[5:3];
  assign cur_c = cur_q.node[2:0];

  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_in = 1'b0;
    case (dir_q)
      DirUp: begin
        nb_r  = cur_r - 3'd1;
        nb_in = (cur_r != 3'd0);
      end
      DirDown: begin
        nb_r  = cur_r + 3'd1;
        nb_in = (({1'b0, cur_r} + 4'd1) < nrows);
      end
      DirLeft: begin
        nb_c  = cur_c - 3'd1;
        nb_in = (cur_c != 3'd0);
      end
      DirRight: begin
        nb_c  = cur_c + 3'd1;
        nb_in = (({1'b0, cur_c} + 4'd1) < ncols);
      end
      default: ;
    endcase
  end

  assign nb_cell = {nb_r, nb_c};
  assign nb_g    = cur_q.g + 7'd1;
  assign nb_h    = absdiff3(nb_r, goal_cell_q[5:3]) + absdiff3(nb_c, goal_cell_q[2:0]);
  assign push_ok = (state_q == ST_EXPAND) && nb_in && !blocked_q[nb_cell] &&
                   !visited_q[nb_cell] && !vld[OPEN_DEPTH-1];

  always_comb begin
    if (state_q == ST_SEED) begin
      new_ent.f    = {4'd0, h_start};
      new_ent.g    = 7'd0;
      new_ent.node = start_cell_q;
      new_ent.src  = start_cell_q;
    end else begin
      new_ent.f    = {1'b0, nb_g} + {4'd0, nb_h};
      new_ent.g    = nb_g;
      new_ent.node = nb_cell;
      new_ent.src  = cur_q.node;
    end
  end

  assign ctl.clear = accept;
  assign ctl.push  = (state_q == ST_SEED) || push_ok;
  assign ctl.pop   = (state_q == ST_POP) && vld[0];

  for (genvar i = 0; i < OPEN_DEPTH; i++) begin : g_chain
    open_entry_t pe, ne;
    logic        pv, pp, nv;
    if (i == 0) begin : g_first
      assign pe = new_ent;
      assign pv = 1'b0;
      assign pp = 1'b0;
    end else begin : g_mid
      assign pe = ent[i-1];
      assign pv = vld[i-1];
      assign pp = place[i-1];
    end
    if (i == OPEN_DEPTH - 1) begin : g_last
      assign ne = new_ent;
      assign nv = 1'b0;
    end else begin : g_inner
      assign ne = ent[i+1];
      assign nv = vld[i+1];
    end
    gra_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_i        (new_ent),
      .prev_ent_i   (pe),
      .prev_vld_i   (pv),
      .prev_place_i (pp),
      .next_ent_i   (ne),
      .next_vld_i   (nv),
      .ent_o        (ent[i]),
      .vld_o        (vld[i]),
      .place_o      (place[i])
    );
  end

  assign head_new = vld[0] && !visited_q[ent[0].node];
  assign rd_off   = len_q - 7'd1 - {1'b0, k_q};

  always_ff @(posedge clk_i) begin
    if (ctl.pop && head_new) begin
      parent_mem[ent[0].node] <= ent[0].src;
    end
    if (state_q == ST_TRACE) begin
      trail_mem[n_q] <= at_q;
      parent_rd_q    <= parent_mem[at_q];
    end
    if (state_q == ST_EMIT) begin
      trail_rd_q <= trail_mem[rd_off[5:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rows_q       <= 4'd8;
      cols_q       <= 4'd8;
      blocked_q    <= '0;
      visited_q    <= '0;
      start_cell_q <= '0;
      goal_cell_q  <= '0;
      cur_q        <= '0;
      dir_q        <= DirUp;
      at_q         <= '0;
      n_q          <= '0;
      k_q          <= '0;
      len_q        <= '0;
      res_vld_q    <= 1'b0;
      res_found_q  <= 1'b0;
      res_last_q   <= 1'b0;
      res_cell_q   <= '0;
      res_idx_q    <= '0;
    end else begin
      res_vld_q <= (state_q == ST_EMIT_OUT) || (state_q == ST_FAIL);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgRows:    rows_q    <= cfg_data_i[3:0];
          CfgCols:    cols_q    <= cfg_data_i[3:0];
          CfgBlocked: blocked_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            visited_q    <= '0;
            start_cell_q <= {start_row_i, start_col_i};
            goal_cell_q  <= {goal_row_i, goal_col_i};
            state_q      <= outside ? ST_FAIL : ST_SEED;
          end
        end
        ST_SEED: begin
          state_q <= ST_POP;
        end
        ST_POP: begin
          if (!vld[0]) begin
            state_q <= ST_FAIL;
          end else if (head_new) begin
            visited_q[ent[0].node] <= 1'b1;
            cur_q                  <= ent[0];
            if (ent[0].node == goal_cell_q) begin
              at_q    <= goal_cell_q;
              n_q     <= '0;
              state_q <= ST_TRACE;
            end else begin
              dir_q   <= DirUp;
              state_q <= ST_EXPAND;
            end
          end
        end
        ST_EXPAND: begin
          dir_q <= dir_q + 2'd1;
          if (dir_q == DirRight) begin
            state_q <= ST_POP;
          end
        end
        ST_TRACE: begin
          if (at_q == start_cell_q || n_q == 6'd63) begin
            len_q   <= {1'b0, n_q} + 7'd1;
            k_q     <= '0;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_TRACE_WAIT;
          end
        end
        ST_TRACE_WAIT: begin
          at_q    <= parent_rd_q;
          n_q     <= n_q + 6'd1;
          state_q <= ST_TRACE;
        end
        ST_EMIT: begin
          state_q <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          res_found_q <= 1'b1;
          res_cell_q  <= trail_rd_q;
          res_idx_q   <= k_q;
          res_last_q  <= ({1'b0, k_q} + 7'd1 == len_q);
          k_q         <= k_q + 6'd1;
          state_q     <= ({1'b0, k_q} + 7'd1 == len_q) ? ST_IDLE : ST_EMIT;
        end
        ST_FAIL: begin
          res_found_q <= 1'b0;
          res_cell_q  <= '0;
          res_idx_q   <= '0;
          res_last_q  <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_vld_q;
  assign found_o        = res_found_q;
  assign path_row_o     = res_cell_q[5:3];
  assign path_col_o     = res_cell_q[2:0];
  assign step_index_o   = res_idx_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result strobe right after accepting a search");

  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (last_o && path_row_o == 3'd0 &&
                                      path_col_o == 3'd0 && step_index_o == 6'd0))
    else $error("no-path result not a single zeroed result");

  a_head_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[0] && vld[1]) |-> (ent[0].f <= ent[1].f))
    else $error("open list head out of order");

  a_busy_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("unit idle in the middle of a path");
`endif

endmodule

// ===== test/grid_astar_path_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Grid A* path search unit testbench
// Drives search transactions between grid register settings, predicts every
// path cell with a behavioral A* search and checks each result strobe.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit_tb;
  import gra_pkg::*;

  typedef struct packed {
    logic [2:0] sr;
    logic [2:0] sc;
    logic [2:0] gr;
    logic [2:0] gc;
  } search_req_t;

  typedef struct packed {
    logic       found;
    logic [2:0] prow;
    logic [2:0] pcol;
    logic [5:0] step;
    logic       last;
  } path_cell_t;

  localparam int WatchdogLimit = 40000;
  localparam int SearchDepth   = 256;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  start_row_i = '0, start_col_i = '0, goal_row_i = '0, goal_col_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgRows;
  logic [63:0] cfg_data_i = '0;
  logic        result_valid_o, found_o, last_o;
  logic [2:0]  path_row_o, path_col_o;
  logic [5:0]  step_index_o;

  grid_astar_path_search_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // grid settings mirrored for prediction
  logic [3:0]  grid_rows = 4'd8;
  logic [3:0]  grid_cols = 4'd8;
  logic [63:0] grid_blocked = '0;

  search_req_t pending_searches[$];
  path_cell_t  expected_cells[$];
  int          failures = 0;
  int          idle_cycles = 0;
  int          searches_taken = 0;
  bit          cfg_busy = 1'b0;

  function automatic int adist(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic predict_path(input search_req_t q);
    int nr, nc, sr, sc, gr, gc, cnt, seq, best, cur, d, n, at, xr, xc;
    int of[SearchDepth], og[SearchDepth], ocell[SearchDepth];
    int ofrom[SearchDepth], oseq[SearchDepth];
    bit seen[64];
    int par[64];
    int trail[64];
    path_cell_t pc;
    int dr[4] = '{-1, 1, 0, 0};
    int dc[4] = '{0, 0, -1, 1};
    nr = (grid_rows > 8) ? 8 : grid_rows;
    nc = (grid_cols > 8) ? 8 : grid_cols;
    sr = q.sr; sc = q.sc; gr = q.gr; gc = q.gc;
    for (int i = 0; i < 64; i++) begin
      seen[i] = 1'b0;
      par[i] = 0;
    end
    if (sr >= nr || sc >= nc || gr >= nr || gc >= nc) begin
      expected_cells.push_back('{1'b0, 3'd0, 3'd0, 6'd0, 1'b1});
      return;
    end
    of[0] = adist(sr, gr) + adist(sc, gc);
    og[0] = 0; ocell[0] = sr * 8 + sc; ofrom[0] = ocell[0]; oseq[0] = 0;
    cnt = 1; seq = 1;
    while (cnt > 0) begin
      best = 0;
      for (int i = 1; i < cnt; i++)
        if (of[i] < of[best] || (of[i] == of[best] && oseq[i] < oseq[best])) best = i;
      cur = best;
      at = ocell[cur];
      d = og[cur];
      n = ofrom[cur];
      cnt--;
      of[cur] = of[cnt]; og[cur] = og[cnt]; ocell[cur] = ocell[cnt];
      ofrom[cur] = ofrom[cnt]; oseq[cur] = oseq[cnt];
      if (seen[at]) continue;
      seen[at] = 1'b1;
      par[at] = n;
      if (at == gr * 8 + gc) begin
        n = 0;
        while (n < 64) begin
          trail[n++] = at;
          if (at == sr * 8 + sc) break;
          at = par[at];
        end
        for (int k = 0; k < n; k++) begin
          pc.found = 1'b1;
          pc.prow = 3'(trail[n-1-k] / 8);
          pc.pcol = 3'(trail[n-1-k] % 8);
          pc.step = 6'(k);
          pc.last = (k + 1 == n);
          expected_cells.push_back(pc);
        end
        return;
      end
      for (int m = 0; m < 4; m++) begin
        xr = at / 8 + dr[m];
        xc = at % 8 + dc[m];
        if (xr < 0 || xc < 0 || xr >= nr || xc >= nc) continue;
        if (grid_blocked[xr*8+xc] || seen[xr*8+xc]) continue;
        if (cnt >= SearchDepth) continue;
        of[cnt] = d + 1 + adist(xr, gr) + adist(xc, gc);
        og[cnt] = d + 1; ocell[cnt] = xr * 8 + xc; ofrom[cnt] = at;
        oseq[cnt] = seq & 9'h1ff;
        seq++;
        cnt++;
      end
    end
    expected_cells.push_back('{1'b0, 3'd0, 3'd0, 6'd0, 1'b1});
  endtask

  // driver
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (start && !busy) begin
      predict_path(pending_searches.pop_front());
      searches_taken++;
    end
    if (start && busy) begin
      // hold the transaction until taken
    end else if (gap_left > 0 || cfg_busy || pending_searches.size() == 0) begin
      start <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
    end else begin
      start <= 1'b1;
      start_row_i <= pending_searches[0].sr;
      start_col_i <= pending_searches[0].sc;
      goal_row_i  <= pending_searches[0].gr;
      goal_col_i  <= pending_searches[0].gc;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 6);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    path_cell_t got, want;
    if (result_valid_o) begin
      got = '{found_o, path_row_o, path_col_o, step_index_o, last_o};
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failures++;
      end else begin
        want = expected_cells.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, got);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (result_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("grid_astar_path_search_unit_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgRows: grid_rows = val[3:0];
      CfgCols: grid_cols = val[3:0];
      default: grid_blocked = val;
    endcase
  endtask

  task automatic drain;
    int total;
    total = searches_taken + pending_searches.size();
    while (pending_searches.size() > 0 || searches_taken < total ||
           expected_cells.size() > 0 || busy || start)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apply_grid(input logic [3:0] r, input logic [3:0] c, input logic [63:0] b);
    drain();
    cfg_busy = 1'b1;
    write_reg(CfgRows, {60'd0, r});
    write_reg(CfgCols, {60'd0, c});
    write_reg(CfgBlocked, b);
    cfg_busy = 1'b0;
  endtask

  function automatic search_req_t rand_req(input int span);
    search_req_t q;
    q.sr = 3'($urandom_range(0, span)); q.sc = 3'($urandom_range(0, span));
    q.gr = 3'($urandom_range(0, span)); q.gc = 3'($urandom_range(0, span));
    return q;
  endfunction

  function automatic logic [63:0] rand_walls(input int density);
    logic [63:0] b;
    for (int i = 0; i < 64; i++) b[i] = ($urandom_range(0, 99) < density);
    return b;
  endfunction

  initial begin
    logic [3:0] r, c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // open 8x8 grid extremes, corners and same cell
    pending_searches.push_back('{3'd0, 3'd0, 3'd7, 3'd7});
    pending_searches.push_back('{3'd7, 3'd7, 3'd0, 3'd0});
    pending_searches.push_back('{3'd3, 3'd4, 3'd3, 3'd4});
    pending_searches.push_back('{3'd7, 3'd0, 3'd0, 3'd7});
    drain();
    // wall with blocked start and blocked goal
    apply_grid(4'd8, 4'd8, 64'h0000_0000_FF00_0000 | 64'h1 | (64'h1 << 63));
    pending_searches.push_back('{3'd0, 3'd0, 3'd0, 3'd0});
    pending_searches.push_back('{3'd0, 3'd0, 3'd2, 3'd2});
    pending_searches.push_back('{3'd1, 3'd1, 3'd7, 3'd7});
    pending_searches.push_back('{3'd0, 3'd0, 3'd6, 3'd6});
    pending_searches.push_back('{3'd2, 3'd5, 3'd1, 3'd3});
    // small grid with outside cells, over-range register values, zero size
    apply_grid(4'd1, 4'd1, 64'h0);
    pending_searches.push_back('{3'd0, 3'd0, 3'd0, 3'd0});
    pending_searches.push_back('{3'd0, 3'd0, 3'd0, 3'd1});
    apply_grid(4'd15, 4'd9, 64'hAAAA_5555_0000_0000);
    pending_searches.push_back('{3'd7, 3'd7, 3'd0, 3'd0});
    pending_searches.push_back('{3'd0, 3'd0, 3'd3, 3'd7});
    apply_grid(4'd0, 4'd3, 64'h0);
    pending_searches.push_back('{3'd0, 3'd0, 3'd0, 3'd1});
    apply_grid(4'd3, 4'd8, 64'hFFFF_FFFF_FFFF_FF00);
    pending_searches.push_back('{3'd0, 3'd0, 3'd0, 3'd7});
    pending_searches.push_back('{3'd2, 3'd0, 3'd0, 3'd0});
    // random phases, mostly in-grid searches
    for (int ph = 0; ph < 10; ph++) begin
      r = (ph % 4 == 0) ? 4'd8 : 4'($urandom_range(1, 8));
      c = (ph % 3 == 0) ? 4'd8 : 4'($urandom_range(1, 8));
      if (ph == 9) begin r = 4'($urandom_range(0, 15)); c = 4'($urandom_range(0, 15)); end
      apply_grid(r, c, (ph == 5) ? 64'hFFFF_FFFF_FFFF_FFFF : rand_walls($urandom_range(0, 35)));
      for (int i = 0; i < 15; i++) begin
        if ($urandom_range(0, 4) == 0) pending_searches.push_back(rand_req(7));
        else pending_searches.push_back(rand_req(((r > c) ? c : r) - 1));
      end
    end
    drain();
    if (failures == 0) begin
      $display("grid_astar_path_search_unit_tb passed");
    end else begin
      $display("grid_astar_path_search_unit_tb failed");
    end
    $finish;
  end

endmodule
